### rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: keypad code lock shared definitions
// Field widths, reset values, register indexes and event/phase codes.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int KCL_CODE_LEN = 4;
    localparam int KEY_W        = 8;
    localparam int TIMER_W      = 16;
    localparam int FAIL_W       = 3;
    localparam int CNT_OUT_W    = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [KEY_W-1:0]   RESET_KEY       = 8'h31;
    localparam logic [TIMER_W-1:0] DOOR_TICKS_RST  = 16'd2000;
    localparam logic [TIMER_W-1:0] LOCK_TICKS_RST  = 16'd5000;
    localparam logic [FAIL_W-1:0]  MAX_FAIL_RST    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAIL   = 2'd2;

    localparam logic MODE_CHANGE = 1'b0;
    localparam logic MODE_ENTER  = 1'b1;

    typedef enum logic [1:0] {
        KIND_KEY  = 2'd0,
        KIND_TICK = 2'd1,
        KIND_MODE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_OLD     = 3'd1,
        PH_NEW     = 3'd2,
        PH_UNLOCK  = 3'd3,
        PH_LOCKOUT = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_DIGIT   = 3'd1,
        EV_RIGHT   = 3'd2,
        EV_WRONG   = 3'd3,
        EV_LOCKOUT = 3'd4,
        EV_CHANGED = 3'd5,
        EV_IGNORED = 3'd6
    } t_event;

endpackage

### rtl/kcl_in_if.sv
// ----------------------------------------------------------------------------
// kcl_in_if: keypad code lock input channel
// Valid/ready channel carrying one key, tick or mode request.
// ----------------------------------------------------------------------------
interface kcl_in_if;

    logic                      valid;
    logic                      ready;
    kcl_pkg::t_kind            kind;
    logic [kcl_pkg::KEY_W-1:0] key_char;
    logic                      mode_choice;

    modport source (output valid, output kind, output key_char, output mode_choice,
                    input ready);
    modport sink   (input valid, input kind, input key_char, input mode_choice,
                    output ready);

endinterface

### rtl/kcl_out_if.sv
// ----------------------------------------------------------------------------
// kcl_out_if: keypad code lock result channel
// Valid/ready channel carrying the lock status after each request.
// ----------------------------------------------------------------------------
interface kcl_out_if;

    logic                          valid;
    logic                          ready;
    logic                          door_open;
    kcl_pkg::t_event               event_res;
    kcl_pkg::t_phase               phase;
    logic [kcl_pkg::CNT_OUT_W-1:0] digits_entered;

    modport source (output valid, output door_open, output event_res, output phase,
                    output digits_entered, input ready);
    modport sink   (input valid, input door_open, input event_res, input phase,
                    input digits_entered, output ready);

endinterface

### rtl/keypad_code_lock_controller_top.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_top: four-key code lock controller
// Collects key presses, changes the stored code, opens the door on a
// correct code and locks out keys after repeated wrong codes.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per handshake: a key press, a 1 ms tick or a
//   mode selection. o_res returns exactly one result per request: door
//   drive, event code, phase and digit count after that request.
//   Configuration (door time, lockout time, failure limit) is written on
//   i_cfg_we/i_cfg_idx/i_cfg_wdata; the user must write it only while no
//   request is in flight, as the block itself does not enforce this.
//   An accepted request is captured in the input register, then passes
//   through the update logic into the result register.
//   Throughput: one request per cycle while o_res is not stalled; the code
//   compare and timer updates are done in the single update stage.
//   Reset: phase idle, counts and timers zero, stored code all '1',
//   configuration registers at their default values.
//   Stall: when o_res.ready is low the result register holds; one more
//   request is held in the input register, then i_req.ready drops.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_top #(
    parameter int CODE_LEN = kcl_pkg::KCL_CODE_LEN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    kcl_in_if.sink                             i_req,
    kcl_out_if.source                          o_res
);

    import kcl_pkg::*;

    localparam int CNT_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

    // configuration
    logic [TIMER_W-1:0] r_door_ticks;
    logic [TIMER_W-1:0] r_lock_ticks;
    logic [FAIL_W-1:0]  r_max_fail;

    // input stage
    logic               r_in_valid;
    t_kind              r_in_kind;
    logic [KEY_W-1:0]   r_in_key;
    logic               r_in_mode;

    // lock state
    t_phase             r_phase,    n_phase;
    logic [CNT_W-1:0]   r_cnt,      n_cnt;
    logic [KEY_W-1:0]   r_entry     [CODE_LEN];
    logic [KEY_W-1:0]   n_entry     [CODE_LEN];
    logic [KEY_W-1:0]   r_stored    [CODE_LEN];
    logic [KEY_W-1:0]   n_stored    [CODE_LEN];
    logic [FAIL_W-1:0]  r_fail,     n_fail;
    logic [TIMER_W-1:0] r_lock_tmr, n_lock_tmr;
    logic [TIMER_W-1:0] r_door_tmr, n_door_tmr;
    t_event             n_event;

    // result stage
    logic                 r_out_valid;
    logic                 r_out_door;
    t_event               r_out_event;
    t_phase               r_out_phase;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic               w_out_free;
    logic               w_fire;
    logic               w_take_in;
    logic               w_last;
    logic               w_match;
    logic [FAIL_W-1:0]  w_fail_inc;
    logic [31:0]        w_cnt_ext;
    logic [KEY_W-1:0]   w_full [CODE_LEN];

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_fire      = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_free;
    assign w_take_in   = i_req.valid && i_req.ready;

    assign w_last     = (r_cnt == CNT_W'(CODE_LEN - 1));
    assign w_fail_inc = r_fail + FAIL_W'(1);
    assign w_cnt_ext  = 32'(n_cnt);

    // entry with the current key as the last digit
    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < CODE_LEN; i++) begin
            w_full[i] = (i == CODE_LEN - 1) ? r_in_key : r_entry[i];
            if (w_full[i] != r_stored[i]) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_entry    = r_entry;
        n_stored   = r_stored;
        n_fail     = r_fail;
        n_lock_tmr = r_lock_tmr;
        n_door_tmr = r_door_tmr;
        n_event    = EV_IGNORED;
        case (r_in_kind)
            KIND_KEY: begin
                if (r_phase == PH_OLD || r_phase == PH_NEW || r_phase == PH_UNLOCK) begin
                    n_entry[r_cnt] = r_in_key;
                    if (!w_last) begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_event = EV_DIGIT;
                    end else begin
                        n_cnt = '0;
                        case (r_phase)
                            PH_OLD: begin
                                if (w_match) begin
                                    n_phase = PH_NEW;
                                    n_event = EV_RIGHT;
                                end else begin
                                    n_event = EV_WRONG;
                                end
                            end
                            PH_NEW: begin
                                n_stored = w_full;
                                n_phase  = PH_IDLE;
                                n_event  = EV_CHANGED;
                            end
                            default: begin
                                if (w_match) begin
                                    n_door_tmr = r_door_ticks;
                                    n_fail     = '0;
                                    n_phase    = PH_IDLE;
                                    n_event    = EV_RIGHT;
                                end else if (w_fail_inc >= r_max_fail) begin
                                    n_fail     = '0;
                                    n_lock_tmr = r_lock_ticks;
                                    n_phase    = PH_LOCKOUT;
                                    n_event    = EV_LOCKOUT;
                                end else begin
                                    n_fail  = w_fail_inc;
                                    n_event = EV_WRONG;
                                end
                            end
                        endcase
                    end
                end
            end
            KIND_TICK: begin
                n_event = EV_NONE;
                if (r_door_tmr != '0) begin
                    n_door_tmr = r_door_tmr - TIMER_W'(1);
                end
                if (r_phase == PH_LOCKOUT) begin
                    if (r_lock_tmr > TIMER_W'(1)) begin
                        n_lock_tmr = r_lock_tmr - TIMER_W'(1);
                    end else begin
                        n_lock_tmr = '0;
                        n_phase    = PH_UNLOCK;
                        n_cnt      = '0;
                    end
                end
            end
            KIND_MODE: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = (r_in_mode == MODE_ENTER) ? PH_UNLOCK : PH_OLD;
                    n_cnt   = '0;
                    n_event = EV_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_ticks <= DOOR_TICKS_RST;
            r_lock_ticks <= LOCK_TICKS_RST;
            r_max_fail   <= MAX_FAIL_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_IDLE;
            r_cnt        <= '0;
            r_fail       <= '0;
            r_lock_tmr   <= '0;
            r_door_tmr   <= '0;
            for (int i = 0; i < CODE_LEN; i++) begin
                r_stored[i] <= RESET_KEY;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DOOR_TICKS: r_door_ticks <= i_cfg_wdata[TIMER_W-1:0];
                    CFG_LOCK_TICKS: r_lock_ticks <= i_cfg_wdata[TIMER_W-1:0];
                    CFG_MAX_FAIL:   r_max_fail   <= i_cfg_wdata[FAIL_W-1:0];
                    default: ;
                endcase
            end

            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_take_in) begin
                r_in_kind <= i_req.kind;
                r_in_key  <= i_req.key_char;
                r_in_mode <= i_req.mode_choice;
            end

            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_entry     <= n_entry;
                r_stored    <= n_stored;
                r_fail      <= n_fail;
                r_lock_tmr  <= n_lock_tmr;
                r_door_tmr  <= n_door_tmr;
                r_out_door  <= (n_door_tmr != '0);
                r_out_event <= n_event;
                r_out_phase <= n_phase;
                r_out_cnt   <= w_cnt_ext[CNT_OUT_W-1:0];
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.door_open      = r_out_door;
    assign o_res.event_res      = r_out_event;
    assign o_res.phase          = r_out_phase;
    assign o_res.digits_entered = r_out_cnt;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) < CODE_LEN)
        else $error("digit count out of range");

    a_lockout_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LOCKOUT |-> r_fail == '0)
        else $error("failure count not cleared in lockout");

    a_no_entry_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_LOCKOUT) |-> r_cnt == '0)
        else $error("digits counted outside an entry phase");

    a_lockout_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_LOCKOUT) |->
            (r_out_phase == PH_LOCKOUT && r_out_cnt == '0))
        else $error("lockout event without lockout phase");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed request produced no result");

endmodule
